// ----- rtl/pic_instruction_decoder_top_defines.svh -----
// Assertion helpers shared by the decoder RTL.
// Both sample on clk and are off while arst_n is low.
`ifndef PIC_INSTRUCTION_DECODER_TOP_DEFINES_SVH
`define PIC_INSTRUCTION_DECODER_TOP_DEFINES_SVH

// Same-cycle implication
`define PICID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PICID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/picid_pkg.sv -----
package picid_pkg;

	// Operand forms
	localparam logic [2:0] FORM_NONE = 3'd0;
	localparam logic [2:0] FORM_TRIS = 3'd1;
	localparam logic [2:0] FORM_FILE = 3'd2;
	localparam logic [2:0] FORM_FD   = 3'd3;
	localparam logic [2:0] FORM_FB   = 3'd4;
	localparam logic [2:0] FORM_LIT  = 3'd5;
	localparam logic [2:0] FORM_CALL = 3'd6;
	localparam logic [2:0] FORM_GOTO = 3'd7;

	// Flow flags of a table entry
	localparam logic [2:0] FL_NONE = 3'b000;
	localparam logic [2:0] FL_END  = 3'b100;
	localparam logic [2:0] FL_REF  = 3'b010;
	localparam logic [2:0] FL_CODE = 3'b001;

	// Mnemonic codes, in order of first appearance
	typedef enum logic [5:0] {
		MN_NOP, MN_OPTION, MN_SLEEP, MN_CLRWDT, MN_TRIS, MN_MOVWF, MN_CLRW,
		MN_CLRF, MN_SUBWF, MN_DECF, MN_IORWF, MN_ANDWF, MN_XORWF, MN_ADDWF,
		MN_MOVF, MN_COMF, MN_INCF, MN_DECFSZ, MN_RRF, MN_RLF, MN_SWAPF,
		MN_INCFSZ, MN_BCF, MN_BSF, MN_BTFSC, MN_BTFSS, MN_RETLW, MN_CALL,
		MN_GOTO, MN_MOVLW, MN_IORLW, MN_ANDLW, MN_XORLW, MN_RETURN, MN_RETFIE,
		MN_SUBLW, MN_ADDLW
	} mnem_t;

	typedef struct packed {
		logic [13:0] mask;
		logic [13:0] match;
		mnem_t       mnem;
		logic [2:0]  form;
		logic [2:0]  flags;
	} entry_t;

	typedef struct packed {
		logic [13:0] instr_word;
		logic [15:0] byte_address;
		logic        address_outside;
	} item_t;

	typedef struct packed {
		logic        is_valid;
		logic [5:0]  mnemonic;
		logic [2:0]  operand_form;
		logic [6:0]  file_register;
		logic        dest_bit;
		logic [2:0]  bit_number;
		logic [7:0]  literal;
		logic [15:0] ref_address;
		logic        ends_flow;
		logic        has_ref;
		logic        code_ref;
	} result_t;

	localparam int BASE_COUNT = 33;
	localparam int MID_COUNT  = 35;

	// 12-bit baseline table, searched first hit first
	localparam entry_t BASE_TAB [BASE_COUNT] = '{
		'{14'h0FFF, 14'h0000, MN_NOP,    FORM_NONE, FL_NONE},
		'{14'h0FFF, 14'h0002, MN_OPTION, FORM_NONE, FL_NONE},
		'{14'h0FFF, 14'h0003, MN_SLEEP,  FORM_NONE, FL_NONE},
		'{14'h0FFF, 14'h0004, MN_CLRWDT, FORM_NONE, FL_NONE},
		'{14'h0FF8, 14'h0000, MN_TRIS,   FORM_TRIS, FL_NONE},
		'{14'h0FE0, 14'h0020, MN_MOVWF,  FORM_FILE, FL_NONE},
		'{14'h0FFF, 14'h0040, MN_CLRW,   FORM_NONE, FL_NONE},
		'{14'h0FE0, 14'h0060, MN_CLRF,   FORM_FILE, FL_NONE},
		'{14'h0FC0, 14'h0080, MN_SUBWF,  FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h00C0, MN_DECF,   FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h0100, MN_IORWF,  FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h0140, MN_ANDWF,  FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h0180, MN_XORWF,  FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h01C0, MN_ADDWF,  FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h0200, MN_MOVF,   FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h0240, MN_COMF,   FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h0280, MN_INCF,   FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h02C0, MN_DECFSZ, FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h0300, MN_RRF,    FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h0340, MN_RLF,    FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h0380, MN_SWAPF,  FORM_FD,   FL_NONE},
		'{14'h0FC0, 14'h03C0, MN_INCFSZ, FORM_FD,   FL_NONE},
		'{14'h0F00, 14'h0400, MN_BCF,    FORM_FB,   FL_NONE},
		'{14'h0F00, 14'h0500, MN_BSF,    FORM_FB,   FL_NONE},
		'{14'h0F00, 14'h0600, MN_BTFSC,  FORM_FB,   FL_REF | FL_CODE},
		'{14'h0F00, 14'h0700, MN_BTFSS,  FORM_FB,   FL_REF | FL_CODE},
		'{14'h0F00, 14'h0800, MN_RETLW,  FORM_LIT,  FL_END},
		'{14'h0F00, 14'h0900, MN_CALL,   FORM_CALL, FL_REF | FL_CODE},
		'{14'h0E00, 14'h0A00, MN_GOTO,   FORM_GOTO, FL_END | FL_REF | FL_CODE},
		'{14'h0F00, 14'h0C00, MN_MOVLW,  FORM_LIT,  FL_NONE},
		'{14'h0F00, 14'h0D00, MN_IORLW,  FORM_LIT,  FL_NONE},
		'{14'h0F00, 14'h0E00, MN_ANDLW,  FORM_LIT,  FL_NONE},
		'{14'h0F00, 14'h0F00, MN_XORLW,  FORM_LIT,  FL_NONE}
	};

	// 14-bit midrange table, searched first hit first
	localparam entry_t MID_TAB [MID_COUNT] = '{
		'{14'h3F9F, 14'h0000, MN_NOP,    FORM_NONE, FL_NONE},
		'{14'h3FFF, 14'h0008, MN_RETURN, FORM_NONE, FL_END},
		'{14'h3FFF, 14'h0009, MN_RETFIE, FORM_NONE, FL_END},
		'{14'h3FFF, 14'h0063, MN_SLEEP,  FORM_NONE, FL_NONE},
		'{14'h3FFF, 14'h0064, MN_CLRWDT, FORM_NONE, FL_NONE},
		'{14'h3F80, 14'h0080, MN_MOVWF,  FORM_FILE, FL_NONE},
		'{14'h3F80, 14'h0100, MN_CLRW,   FORM_NONE, FL_NONE},
		'{14'h3F80, 14'h0180, MN_CLRF,   FORM_FILE, FL_NONE},
		'{14'h3F00, 14'h0200, MN_SUBWF,  FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0300, MN_DECF,   FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0400, MN_IORWF,  FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0500, MN_ANDWF,  FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0600, MN_XORWF,  FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0700, MN_ADDWF,  FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0800, MN_MOVF,   FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0900, MN_COMF,   FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0A00, MN_INCF,   FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0B00, MN_DECFSZ, FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0C00, MN_RRF,    FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0D00, MN_RLF,    FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0E00, MN_SWAPF,  FORM_FD,   FL_NONE},
		'{14'h3F00, 14'h0F00, MN_INCFSZ, FORM_FD,   FL_NONE},
		'{14'h3C00, 14'h1000, MN_BCF,    FORM_FB,   FL_NONE},
		'{14'h3C00, 14'h1400, MN_BSF,    FORM_FB,   FL_NONE},
		'{14'h3C00, 14'h1800, MN_BTFSC,  FORM_FB,   FL_NONE},
		'{14'h3C00, 14'h1C00, MN_BTFSS,  FORM_FB,   FL_NONE},
		'{14'h3800, 14'h2000, MN_CALL,   FORM_CALL, FL_REF | FL_CODE},
		'{14'h3800, 14'h2800, MN_GOTO,   FORM_GOTO, FL_END | FL_REF | FL_CODE},
		'{14'h3C00, 14'h3000, MN_MOVLW,  FORM_LIT,  FL_NONE},
		'{14'h3C00, 14'h3400, MN_RETLW,  FORM_LIT,  FL_END},
		'{14'h3F00, 14'h3800, MN_IORLW,  FORM_LIT,  FL_NONE},
		'{14'h3F00, 14'h3900, MN_ANDLW,  FORM_LIT,  FL_NONE},
		'{14'h3F00, 14'h3A00, MN_XORLW,  FORM_LIT,  FL_NONE},
		'{14'h3E00, 14'h3C00, MN_SUBLW,  FORM_LIT,  FL_NONE},
		'{14'h3E00, 14'h3E00, MN_ADDLW,  FORM_LIT,  FL_NONE}
	};

endpackage

// ----- rtl/picid_decode.sv -----
module picid_decode (
	input  logic              mid,
	input  picid_pkg::item_t   item,
	output picid_pkg::result_t result
);

	logic [13:0]       w;
	logic              base_hit;
	logic              mid_hit;
	picid_pkg::entry_t base_sel;
	picid_pkg::entry_t mid_sel;
	logic              hit;
	picid_pkg::entry_t sel;
	logic [6:0]        fr;
	logic              dbit;
	logic [2:0]        bnum;

	assign w = item.instr_word;

	// First-hit search: scan from the back so the earliest match wins
	always_comb begin
		base_hit = 1'b0;
		base_sel = '0;
		for (int i = picid_pkg::BASE_COUNT - 1; i >= 0; i--) begin
			if ((w & picid_pkg::BASE_TAB[i].mask) == picid_pkg::BASE_TAB[i].match) begin
				base_hit = 1'b1;
				base_sel = picid_pkg::BASE_TAB[i];
			end
		end
	end

	always_comb begin
		mid_hit = 1'b0;
		mid_sel = '0;
		for (int i = picid_pkg::MID_COUNT - 1; i >= 0; i--) begin
			if ((w & picid_pkg::MID_TAB[i].mask) == picid_pkg::MID_TAB[i].match) begin
				mid_hit = 1'b1;
				mid_sel = picid_pkg::MID_TAB[i];
			end
		end
	end

	assign hit = mid ? mid_hit : base_hit;
	assign sel = mid ? mid_sel : base_sel;

	// Field positions differ by core
	assign fr   = mid ? w[6:0] : {2'b00, w[4:0]};
	assign dbit = mid ? w[7] : w[5];
	assign bnum = mid ? w[9:7] : w[7:5];

	// Operand extraction by form; invalid items give all zeros
	always_comb begin
		result = '0;
		if (hit && !item.address_outside) begin
			result.is_valid     = 1'b1;
			result.mnemonic     = sel.mnem;
			result.operand_form = sel.form;
			result.ends_flow    = (sel.flags & picid_pkg::FL_END) != 3'b000;
			result.has_ref      = (sel.flags & picid_pkg::FL_REF) != 3'b000;
			result.code_ref     = (sel.flags & picid_pkg::FL_CODE) != 3'b000;
			case (sel.form)
				picid_pkg::FORM_TRIS: begin
					result.literal = {5'b00000, w[2:0]};
				end
				picid_pkg::FORM_FILE: begin
					result.file_register = fr;
				end
				picid_pkg::FORM_FD: begin
					result.file_register = fr;
					result.dest_bit      = dbit;
				end
				picid_pkg::FORM_FB: begin
					result.file_register = fr;
					result.bit_number    = bnum;
					// skip target, wraps at 16 bits
					if ((sel.flags & picid_pkg::FL_REF) != 3'b000) begin
						result.ref_address = item.byte_address + 16'd4;
					end
				end
				picid_pkg::FORM_LIT: begin
					result.literal = w[7:0];
				end
				picid_pkg::FORM_CALL: begin
					result.ref_address = mid ? {4'b0000, w[10:0], 1'b0}
						: {7'b0000000, w[7:0], 1'b0};
				end
				picid_pkg::FORM_GOTO: begin
					result.ref_address = mid ? {4'b0000, w[10:0], 1'b0}
						: {6'b000000, w[8:0], 1'b0};
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/pic_instruction_decoder_top.sv -----
// Channel   | Ports                    | Handshake
// ----------+--------------------------+------------------------------------
// item in   | start, busy, item        | taken when start=1 and busy=0
// result    | done, result             | one cycle, strobed by done
// config    | cfg_we, cfg_data         | written when cfg_we=1
//
// One item per cycle; busy is always low.
// Path: input register, table match and field extraction,
// then the result register that drives done and result.
// arst_n clears the pipeline valid bits and selects the baseline core.
// The receiver cannot stall; every result is shown for exactly one cycle.
`include "pic_instruction_decoder_top_defines.svh"

module pic_instruction_decoder_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  picid_pkg::item_t   item,
	output logic               done,
	output picid_pkg::result_t result,
	input  logic               cfg_we,
	input  logic               cfg_data
);

	logic               core_variant_q;
	logic               valid_s1;
	picid_pkg::item_t   item_s1;
	logic               valid_s2;
	picid_pkg::result_t result_s2;
	picid_pkg::result_t dec_result;

	assign busy = 1'b0;

	// Core select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_variant_q <= 1'b0;
		end else if (cfg_we) begin
			core_variant_q <= cfg_data;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	picid_decode u_decode (
		.mid    (core_variant_q),
		.item   (item_s1),
		.result (dec_result)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= dec_result;
		end
	end

	assign done   = valid_s2;
	assign result = result_s2;

	`PICID_ASSERT_NEXT(a_item_enters, start && !busy, valid_s1, "accepted item did not enter stage 1")
	`PICID_ASSERT_NOW(a_invalid_zero, done && !result.is_valid, result == '0, "invalid result not cleared")
	`PICID_ASSERT_NOW(a_ref_code, done && result.has_ref, result.code_ref && result.is_valid, "reference without code flag")
	`PICID_ASSERT_NOW(a_no_ref_zero, done && !result.has_ref, result.ref_address == 16'd0, "stray reference address")

endmodule
